FILE: hdl/rsc_pkg.sv
// Package: shared types, character codes and helper functions for the color command parser.
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

    localparam logic [3:0] PREFIX_LEN = 4'd10;
    localparam logic [8:0] MAG_SAT    = 9'd256;
    localparam logic [8:0] MAG_MAX    = 9'd255;
    localparam logic [1:0] LAST_FIELD = 2'd2;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_RANGE  = 2'd1,
        STATUS_FORMAT = 2'd2
    } status_t;

    // Number phase: leading blanks/sign, sign seen, inside digits
    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2
    } phase_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rsc_result_t;

    // Literal command prefix "SET_COLOR="
    function automatic logic [7:0] prefix_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = 8'h53; // S
            4'd1:    c = 8'h45; // E
            4'd2:    c = 8'h54; // T
            4'd3:    c = 8'h5F; // _
            4'd4:    c = 8'h43; // C
            4'd5:    c = 8'h4F; // O
            4'd6:    c = 8'h4C; // L
            4'd7:    c = 8'h4F; // O
            4'd8:    c = 8'h52; // R
            4'd9:    c = 8'h3D; // =
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // A finished number is legal when it fits 0..255; minus is allowed on zero only
    function automatic logic num_ok(input logic neg, input logic [8:0] mag);
        return (mag <= MAG_MAX) && (!neg || (mag == 9'd0));
    endfunction

endpackage

`default_nettype wire

FILE: hdl/rsc_if.sv
// Interfaces: command character channel and result channel.
`timescale 1ns / 1ps
`default_nettype none

interface rsc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       is_last;

    modport source (output valid, output ch, output is_last, input ready);
    modport sink   (input valid, input ch, input is_last, output ready);
endinterface

interface rsc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output status, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input status, input red, input green, input blue,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/rsc_parser.sv
// Parser core: per-character parse state, command close and stored color.
`timescale 1ns / 1ps
`default_nettype none

module rsc_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire logic [7:0]         ch,
    input  wire logic               is_last,
    output rsc_pkg::rsc_result_t    result
);
    import rsc_pkg::*;

    logic [3:0]  prefix_pos_reg,  prefix_pos_next,  prefix_pos_tk;
    logic [1:0]  field_reg,       field_next,       field_tk;
    phase_t      phase_reg,       phase_next,       phase_tk;
    logic        negative_reg,    negative_next,    negative_tk;
    logic [8:0]  magnitude_reg,   magnitude_next,   magnitude_tk;
    logic        fmt_fail_reg,    fmt_fail_next,    fmt_fail_tk;
    logic        rng_fail_reg,    rng_fail_next,    rng_fail_tk;
    logic        matched_reg,     matched_next,     matched_tk;
    logic [7:0]  pend_red_reg,    pend_red_next,    pend_red_tk;
    logic [7:0]  pend_green_reg,  pend_green_next,  pend_green_tk;
    logic [7:0]  color_red_reg,   color_red_next;
    logic [7:0]  color_green_reg, color_green_next;
    logic [7:0]  color_blue_reg,  color_blue_next;

    logic [12:0] mag_x10;
    logic [8:0]  mag_acc;
    logic        matched_cl;
    logic        rng_fail_cl;
    status_t     status_cl;

    // Decimal accumulate with saturation
    assign mag_x10 = ({4'b0, magnitude_reg} << 3) + ({4'b0, magnitude_reg} << 1)
                   + {9'b0, ch[3:0]};
    assign mag_acc = (mag_x10 > {4'b0, MAG_SAT}) ? MAG_SAT : mag_x10[8:0];

    // Consume one character
    always_comb
    begin
        prefix_pos_tk = prefix_pos_reg;
        field_tk      = field_reg;
        phase_tk      = phase_reg;
        negative_tk   = negative_reg;
        magnitude_tk  = magnitude_reg;
        fmt_fail_tk   = fmt_fail_reg;
        rng_fail_tk   = rng_fail_reg;
        matched_tk    = matched_reg;
        pend_red_tk   = pend_red_reg;
        pend_green_tk = pend_green_reg;
        if (!fmt_fail_reg && !matched_reg)
        begin
            if (prefix_pos_reg < PREFIX_LEN)
            begin
                if (ch == prefix_char(prefix_pos_reg))
                    prefix_pos_tk = prefix_pos_reg + 4'd1;
                else
                    fmt_fail_tk = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LEAD:
                    begin
                        if (is_space(ch))
                        begin
                            phase_tk = PH_LEAD;
                        end
                        else if ((ch == CH_PLUS) || (ch == CH_MINUS))
                        begin
                            negative_tk = (ch == CH_MINUS);
                            phase_tk    = PH_SIGN;
                        end
                        else if (is_digit(ch))
                        begin
                            magnitude_tk = {5'b0, ch[3:0]};
                            phase_tk     = PH_DIGITS;
                        end
                        else
                            fmt_fail_tk = 1'b1;
                    end
                    PH_SIGN:
                    begin
                        if (is_digit(ch))
                        begin
                            magnitude_tk = {5'b0, ch[3:0]};
                            phase_tk     = PH_DIGITS;
                        end
                        else
                            fmt_fail_tk = 1'b1;
                    end
                    default:
                    begin
                        if (is_digit(ch))
                            magnitude_tk = mag_acc;
                        else
                        begin
                            // close the current number
                            if (!num_ok(negative_reg, magnitude_reg))
                                rng_fail_tk = 1'b1;
                            if (field_reg == 2'd0)
                                pend_red_tk = magnitude_reg[7:0];
                            else if (field_reg == 2'd1)
                                pend_green_tk = magnitude_reg[7:0];
                            if (field_reg >= LAST_FIELD)
                                matched_tk = 1'b1;
                            else if (ch == CH_COMMA)
                            begin
                                field_tk     = field_reg + 2'd1;
                                phase_tk     = PH_LEAD;
                                negative_tk  = 1'b0;
                                magnitude_tk = 9'd0;
                            end
                            else
                                fmt_fail_tk = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // Close the command on the last character, form the result and next state
    always_comb
    begin
        matched_cl  = matched_tk;
        rng_fail_cl = rng_fail_tk;
        if (!fmt_fail_tk && !matched_tk && (prefix_pos_tk >= PREFIX_LEN) &&
            (phase_tk == PH_DIGITS) && (field_tk >= LAST_FIELD))
        begin
            matched_cl = 1'b1;
            if (!num_ok(negative_tk, magnitude_tk))
                rng_fail_cl = 1'b1;
        end

        color_red_next   = color_red_reg;
        color_green_next = color_green_reg;
        color_blue_next  = color_blue_reg;
        priority if (fmt_fail_tk || !matched_cl)
            status_cl = STATUS_FORMAT;
        else if (rng_fail_cl)
            status_cl = STATUS_RANGE;
        else
        begin
            status_cl = STATUS_OK;
            if (is_last)
            begin
                color_red_next   = pend_red_tk;
                color_green_next = pend_green_tk;
                color_blue_next  = magnitude_tk[7:0];
            end
        end

        result.status = status_cl;
        result.red    = color_red_next;
        result.green  = color_green_next;
        result.blue   = color_blue_next;

        if (is_last)
        begin
            prefix_pos_next = 4'd0;
            field_next      = 2'd0;
            phase_next      = PH_LEAD;
            negative_next   = 1'b0;
            magnitude_next  = 9'd0;
            fmt_fail_next   = 1'b0;
            rng_fail_next   = 1'b0;
            matched_next    = 1'b0;
            pend_red_next   = 8'd0;
            pend_green_next = 8'd0;
        end
        else
        begin
            prefix_pos_next = prefix_pos_tk;
            field_next      = field_tk;
            phase_next      = phase_tk;
            negative_next   = negative_tk;
            magnitude_next  = magnitude_tk;
            fmt_fail_next   = fmt_fail_tk;
            rng_fail_next   = rng_fail_tk;
            matched_next    = matched_tk;
            pend_red_next   = pend_red_tk;
            pend_green_next = pend_green_tk;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_pos_reg  <= 4'd0;
            field_reg       <= 2'd0;
            phase_reg       <= PH_LEAD;
            negative_reg    <= 1'b0;
            magnitude_reg   <= 9'd0;
            fmt_fail_reg    <= 1'b0;
            rng_fail_reg    <= 1'b0;
            matched_reg     <= 1'b0;
            pend_red_reg    <= 8'd0;
            pend_green_reg  <= 8'd0;
            color_red_reg   <= 8'd0;
            color_green_reg <= 8'd0;
            color_blue_reg  <= 8'd0;
        end
        else if (advance)
        begin
            prefix_pos_reg  <= prefix_pos_next;
            field_reg       <= field_next;
            phase_reg       <= phase_next;
            negative_reg    <= negative_next;
            magnitude_reg   <= magnitude_next;
            fmt_fail_reg    <= fmt_fail_next;
            rng_fail_reg    <= rng_fail_next;
            matched_reg     <= matched_next;
            pend_red_reg    <= pend_red_next;
            pend_green_reg  <= pend_green_next;
            color_red_reg   <= color_red_next;
            color_green_reg <= color_green_next;
            color_blue_reg  <= color_blue_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rgb_set_command_parser.sv
// Top level: color command parser with input register and result register.
//
// Usage:
//   cmd carries one ASCII character per transaction (ch) plus is_last, which
//   marks the final character of a command "SET_COLOR=r,g,b". Every
//   character is parsed; the last one also closes the command.
//   rsp carries one transaction per command: status (0 updated, 1 value out
//   of range, 2 bad format) and the stored red/green/blue after the command.
//   Characters that are not last produce no rsp transaction.
// Path: an accepted character sits in the input register and is parsed when
//   it advances; the result of a last character is loaded into the result
//   register, where rsp shows it.
// Throughput: one character per cycle, back to back, unless a last one waits;
//   the parse step is a single pass of small logic between the two registers.
// Stall: while a result waits in the result register, non-last characters
//   keep flowing; a last character waits in the input register, and cmd.ready
//   drops only when that register is also occupied. Nothing is lost.
// Reset (rst_n low, asynchronous): both registers empty, parse state cleared,
//   stored color set to black (0,0,0).
`timescale 1ns / 1ps
`default_nettype none

module rgb_set_command_parser (
    input wire logic    clk,
    input wire logic    rst_n,
    rsc_char_if.sink    cmd,
    rsc_result_if.source rsp
);
    import rsc_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_ch_reg;
    logic        in_last_reg;
    logic        out_valid_reg, out_valid_next;
    rsc_result_t out_reg;
    rsc_result_t step_result;
    logic        out_free;
    logic        advance;
    logic        take;

    // Advance the held character when its result (if any) has room
    assign out_free = !out_valid_reg || rsp.ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign cmd.ready = !in_valid_reg || advance;
    assign take     = cmd.valid && cmd.ready;

    rsc_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .ch      (in_ch_reg),
        .is_last (in_last_reg),
        .result  (step_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && in_last_reg)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on transaction, hold otherwise
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_ch_reg   <= cmd.ch;
            in_last_reg <= cmd.is_last;
        end
        if (advance && in_last_reg)
            out_reg <= step_result;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_reg.status;
    assign rsp.red    = out_reg.red;
    assign rsp.green  = out_reg.green;
    assign rsp.blue   = out_reg.blue;

    // A result appears only after a last character was parsed
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && in_last_reg))
        else $error("result raised without a closing character");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |-> !(advance && in_last_reg))
        else $error("pending result overwritten");

    // A held character that does not advance stays intact
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_ch_reg)
                                        && $stable(in_last_reg)))
        else $error("held character lost or changed");

endmodule

`default_nettype wire
